>>> design/ternary_heap_second_priority_queue_assert.svh
// assertion macros used by the checker file
`ifndef TERNARY_HEAP_SECOND_PRIORITY_QUEUE_ASSERT_SVH
`define TERNARY_HEAP_SECOND_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, held off during reset
`define THSPQ_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("thspq check failed");

// next-cycle implication, held off during reset
`define THSPQ_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("thspq check failed");

`endif

>>> design/thspq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package thspq_pkg;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_SHORT = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic               op;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] popped_value;
        logic signed [31:0] popped_priority;
        logic               second_valid;
        logic signed [31:0] second_value;
        logic signed [31:0] second_priority;
        logic [6:0]         entry_count;
    } out_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_LAST_RD,
        ST_LAST_GET,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_DN_CHK,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DN_MOVE,
        ST_FIN,
        ST_DONE
    } state_t;

    // a is at least as good as b under the selected order
    function automatic logic rel(input logic mode, input logic signed [31:0] a,
                                 input logic signed [31:0] b);
        logic r;
        r = mode ? (a <= b) : (a >= b);
        return r;
    endfunction

    // x / 3 for x below 4096 by reciprocal multiply
    function automatic logic [11:0] div3(input logic [11:0] x);
        logic [25:0] p;
        p = 26'(x) * 26'd2731;
        return p[24:13];
    endfunction

endpackage
`default_nettype wire

>>> design/thspq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module thspq_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire thspq_pkg::entry_t wdata,
    output thspq_pkg::entry_t     rdata
);
    import thspq_pkg::*;

    entry_t mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

>>> design/ternary_heap_second_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ternary heap queue that serves its second-best entry
// input channel in_valid / in_stall / in_data: op 0 pushes a pair, op 1 pops
// the best child of the root; one transfer per item, one item at a time
// output channel out_valid / out_stall / out_data: one result per item with
// status, popped pair, current second-best pair and entry count
// config channel cfg_valid / cfg_ready / cfg_data sets the order mode; it is
// ready only while no item is in progress
// steps: a push compares against one parent per level (a write on reaching the
// root), then scans the root's children for the second-best; a pop scans them,
// searches the heap for that entry, fetches the last entry, descends level by
// level and scans again; the output register is loaded last; all set by
// the single port heap memory, one read or one write per cycle
// the block takes one item at a time; the next item is taken while a result
// still waits in the output register
// reset empties the heap (count zero) and clears order mode; memory contents
// are not cleared, only entries below the count are read
// a stalled result holds in the output register; a done item waits until it frees
module ternary_heap_second_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire thspq_pkg::in_t   in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output thspq_pkg::out_t       out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_data
);
    import thspq_pkg::*;

    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CHW = IW + 2;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]   pos_reg, pos_next;
    logic [IW-1:0]   bidx_reg, bidx_next;
    logic [1:0]      k_reg, k_next;
    logic            phase_reg, phase_next;
    logic            mode_reg;
    entry_t          mov_reg, mov_next;
    entry_t          best_reg, best_next;
    entry_t          popped_reg, popped_next;
    logic [1:0]      status_reg, status_next;
    logic            out_valid_reg;
    out_t            out_reg;

    logic            ram_we;
    logic [IW-1:0]   ram_addr;
    entry_t          ram_wdata;
    entry_t          rd_ent;

    logic            accept;
    logic            cnt_full;
    logic            cnt_two;
    logic            scan_more;
    logic [CHW-1:0]  pos3;
    logic [CHW-1:0]  child;
    logic            first_child_in;
    logic            dn_more;
    logic [IW-1:0]   parent;
    logic            up_stop;
    logic            find_hit;
    logic            dn_take;
    logic            out_free;
    entry_t          in_ent;

    thspq_ram #(
        .DEPTH(CAPACITY),
        .AW   (IW)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(rd_ent)
    );

    // shared conditions
    assign accept         = in_valid && !in_stall;
    assign in_stall       = (state_reg != ST_IDLE);
    assign cfg_ready      = (state_reg == ST_IDLE);
    assign cnt_full       = (cnt_reg == CW'(CAPACITY));
    assign cnt_two        = (cnt_reg >= CW'(2));
    assign scan_more      = (k_reg != 2'd3) && ((CW'(k_reg) + CW'(1)) < cnt_reg);
    assign pos3           = (CHW'(pos_reg) << 1) + CHW'(pos_reg);
    assign child          = pos3 + CHW'(k_reg);
    assign first_child_in = (pos3 + CHW'(1)) < CHW'(cnt_reg);
    assign dn_more        = (k_reg != 2'd3) && ((child + CHW'(1)) < CHW'(cnt_reg));
    assign parent         = IW'(div3(12'(pos_reg - IW'(1))));
    assign up_stop        = rel(mode_reg, rd_ent.prio, mov_reg.prio);
    assign find_hit       = (rd_ent == best_reg);
    assign dn_take        = rel(mode_reg, rd_ent.prio, best_reg.prio);
    assign out_free       = !out_valid_reg || !out_stall;
    assign in_ent.value   = in_data.item_value;
    assign in_ent.prio    = in_data.item_priority;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.op == OP_PUSH)
                    begin
                        state_next = cnt_full ? ST_FIN : ST_UP_CHK;
                    end
                    else
                    begin
                        state_next = cnt_two ? ST_SCAN_RD : ST_FIN;
                    end
                end
            end
            ST_SCAN_RD:  state_next = ST_SCAN_CMP;
            ST_SCAN_CMP:
            begin
                if (scan_more)
                begin
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    state_next = phase_reg ? ST_DONE : ST_FIND_RD;
                end
            end
            ST_FIND_RD:  state_next = ST_FIND_CMP;
            ST_FIND_CMP: state_next = find_hit ? ST_LAST_RD : ST_FIND_RD;
            ST_LAST_RD:  state_next = ST_LAST_GET;
            ST_LAST_GET: state_next = ST_DN_CHK;
            ST_UP_CHK:   state_next = (pos_reg == '0) ? ST_FIN : ST_UP_CMP;
            ST_UP_CMP:   state_next = up_stop ? ST_FIN : ST_UP_CHK;
            ST_DN_CHK:   state_next = first_child_in ? ST_DN_RD : ST_FIN;
            ST_DN_RD:    state_next = ST_DN_CMP;
            ST_DN_CMP:   state_next = dn_more ? ST_DN_RD : ST_DN_MOVE;
            ST_DN_MOVE:  state_next = (bidx_reg == pos_reg) ? ST_FIN : ST_DN_CHK;
            ST_FIN:      state_next = cnt_two ? ST_SCAN_RD : ST_DONE;
            ST_DONE:     state_next = out_free ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        bidx_next   = bidx_reg;
        k_next      = k_reg;
        phase_next  = phase_reg;
        mov_next    = mov_reg;
        best_next   = best_reg;
        popped_next = popped_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_addr    = pos_reg;
        ram_wdata   = mov_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    popped_next = '0;
                    status_next = STAT_OK;
                    k_next      = 2'd1;
                    phase_next  = 1'b0;
                    if (in_data.op == OP_PUSH)
                    begin
                        if (cnt_full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            mov_next = in_ent;
                            pos_next = IW'(cnt_reg);
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end
                    else if (!cnt_two)
                    begin
                        status_next = STAT_SHORT;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                ram_addr = IW'(k_reg);
            end
            ST_SCAN_CMP:
            begin
                if (k_reg == 2'd1 || rel(mode_reg, rd_ent.prio, best_reg.prio))
                begin
                    best_next = rd_ent;
                end
                if (scan_more)
                begin
                    k_next = k_reg + 2'd1;
                end
                else if (!phase_reg)
                begin
                    bidx_next = '0;
                end
            end
            ST_FIND_RD:
            begin
                ram_addr = bidx_reg;
            end
            ST_FIND_CMP:
            begin
                if (find_hit)
                begin
                    popped_next = best_reg;
                    cnt_next    = cnt_reg - CW'(1);
                end
                else
                begin
                    bidx_next = bidx_reg + IW'(1);
                end
            end
            ST_LAST_RD:
            begin
                ram_addr = IW'(cnt_reg);
            end
            ST_LAST_GET:
            begin
                mov_next = rd_ent;
                pos_next = bidx_reg;
            end
            ST_UP_CHK:
            begin
                if (pos_reg == '0)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_addr = parent;
                end
            end
            ST_UP_CMP:
            begin
                ram_we = 1'b1;
                if (!up_stop)
                begin
                    ram_wdata = rd_ent;
                    pos_next  = parent;
                end
            end
            ST_DN_CHK:
            begin
                if (first_child_in)
                begin
                    bidx_next = pos_reg;
                    best_next = mov_reg;
                    k_next    = 2'd1;
                end
                else
                begin
                    ram_we = 1'b1;
                end
            end
            ST_DN_RD:
            begin
                ram_addr = IW'(child);
            end
            ST_DN_CMP:
            begin
                if (dn_take)
                begin
                    best_next = rd_ent;
                    bidx_next = IW'(child);
                end
                if (dn_more)
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            ST_DN_MOVE:
            begin
                ram_we = 1'b1;
                if (bidx_reg != pos_reg)
                begin
                    ram_wdata = best_reg;
                    pos_next  = bidx_reg;
                end
            end
            ST_FIN:
            begin
                k_next     = 2'd1;
                phase_next = 1'b1;
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // control and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            mode_reg  <= 1'b0;
            phase_reg <= 1'b0;
            k_reg     <= 2'd1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        bidx_reg   <= bidx_next;
        mov_reg    <= mov_next;
        best_reg   <= best_next;
        popped_reg <= popped_next;
        status_reg <= status_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_reg.status          <= status_reg;
            out_reg.popped_value    <= popped_reg.value;
            out_reg.popped_priority <= popped_reg.prio;
            out_reg.second_valid    <= cnt_two;
            out_reg.second_value    <= cnt_two ? best_reg.value : '0;
            out_reg.second_priority <= cnt_two ? best_reg.prio : '0;
            out_reg.entry_count     <= 7'(cnt_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

>>> design/thspq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "ternary_heap_second_priority_queue_assert.svh"
module thspq_checker #(
    parameter int CAPACITY = 64
) (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_stall,
    input wire thspq_pkg::in_t  in_data,
    input wire logic            out_valid,
    input wire logic            out_stall,
    input wire thspq_pkg::out_t out_data,
    input wire logic            cfg_valid,
    input wire logic            cfg_ready,
    input wire logic            cfg_data
);
    import thspq_pkg::*;

    logic in_xfer;
    logic unused_ok;

    assign in_xfer   = in_valid && !in_stall;
    assign unused_ok = ^{in_data, cfg_valid, cfg_ready, cfg_data};

    // one item at a time: a transfer blocks the next cycle
    `THSPQ_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_xfer, in_stall)
    // a stalled result holds
    `THSPQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_data))
    // failed operations report no popped pair
    `THSPQ_ASSERT_NOW(a_fail_no_pop, clk, rst_n, out_valid && out_data.status != STAT_OK,
        out_data.popped_value == 0 && out_data.popped_priority == 0)
    // full push only reported at capacity
    `THSPQ_ASSERT_NOW(a_full_count, clk, rst_n, out_valid && out_data.status == STAT_FULL,
        out_data.entry_count == 7'(CAPACITY))

endmodule

bind ternary_heap_second_priority_queue thspq_checker #(.CAPACITY(CAPACITY)) u_thspq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
);
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
    import thspq_pkg::*;

    localparam int CAP = 64;
    localparam int WATCH_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_t in_data;
    logic out_valid;
    logic out_stall;
    out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;

    ternary_heap_second_priority_queue #(.CAPACITY(CAP)) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // predictor state
    entry_t heap_mdl[CAP];
    int unsigned heap_n;
    logic mode_mdl;

    out_t expected_q[$];
    int errors;
    int pushes_sent;
    int pops_sent;
    int results_seen;
    int idle_cycles;
    bit hold_rx;
    bit sending_done;
    int unsigned rx_gap_max;

    // stimulus table row: op, value, priority, check flag, expected status/count
    typedef struct {
        logic op;
        logic signed [31:0] val;
        logic signed [31:0] pri;
        bit typed;
        logic [1:0] status;
        logic [6:0] count;
    } row_t;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic bit better(logic signed [31:0] a, logic signed [31:0] b);
        return mode_mdl ? (a <= b) : (a >= b);
    endfunction

    function automatic int unsigned second_slot();
        int unsigned c;
        c = 1;
        if (heap_n > 2 && better(heap_mdl[2].prio, heap_mdl[c].prio))
            c = 2;
        if (heap_n > 3 && better(heap_mdl[3].prio, heap_mdl[c].prio))
            c = 3;
        return c;
    endfunction

    // compute the result of one item and update the shadow heap
    function automatic out_t queue_step(in_t it);
        out_t r;
        entry_t t;
        entry_t tgt;
        int unsigned pos;
        int unsigned par;
        int unsigned top;
        int unsigned s;
        int unsigned c;
        r = '0;
        if (it.op == OP_PUSH)
        begin
            if (heap_n >= CAP)
                r.status = STAT_FULL;
            else
            begin
                heap_mdl[heap_n].value = it.item_value;
                heap_mdl[heap_n].prio = it.item_priority;
                pos = heap_n;
                heap_n++;
                while (pos > 0)
                begin
                    par = (pos - 1) / 3;
                    if (better(heap_mdl[par].prio, heap_mdl[pos].prio))
                        break;
                    t = heap_mdl[par];
                    heap_mdl[par] = heap_mdl[pos];
                    heap_mdl[pos] = t;
                    pos = par;
                end
            end
        end
        else
        begin
            if (heap_n < 2)
                r.status = STAT_SHORT;
            else
            begin
                tgt = heap_mdl[second_slot()];
                r.popped_value = tgt.value;
                r.popped_priority = tgt.prio;
                for (int unsigned i = 0; i < heap_n; i++)
                begin
                    if (heap_mdl[i] == tgt)
                    begin
                        heap_n--;
                        heap_mdl[i] = heap_mdl[heap_n];
                        pos = i;
                        while (pos < heap_n)
                        begin
                            top = pos;
                            for (int k = 1; k <= 3; k++)
                            begin
                                c = 3 * pos + k;
                                if (c < heap_n
                                    && better(heap_mdl[c].prio, heap_mdl[top].prio))
                                    top = c;
                            end
                            if (top == pos)
                                break;
                            t = heap_mdl[pos];
                            heap_mdl[pos] = heap_mdl[top];
                            heap_mdl[top] = t;
                            pos = top;
                        end
                        break;
                    end
                end
            end
        end
        if (heap_n >= 2)
        begin
            s = second_slot();
            r.second_valid = 1'b1;
            r.second_value = heap_mdl[s].value;
            r.second_priority = heap_mdl[s].prio;
        end
        r.entry_count = heap_n[6:0];
        return r;
    endfunction

    // receiver side stall
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rx)
                out_stall <= 1'b1;
            else if ($urandom_range(0, 3) == 0)
                out_stall <= 1'b0;
            else if ($urandom_range(0, 2) == 0)
                out_stall <= ($urandom_range(0, rx_gap_max) != 0);
            else
                out_stall <= 1'b0;
        end
    end

    // result checking
    always @(posedge clk)
    begin
        out_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %p", $time, out_data);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (out_data !== exp_r)
                begin
                    errors++;
                    $display("%0t: result mismatch expected %p actual %p",
                             $time, exp_r, out_data);
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // valid stays high into the next item when there is no gap
    task automatic send_item(logic op, logic signed [31:0] v, logic signed [31:0] p,
                             bit typed, logic [1:0] st, logic [6:0] cnt);
        in_t it;
        out_t r;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (sending_done)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.op = op;
        it.item_value = v;
        it.item_priority = p;
        r = queue_step(it);
        if (typed && (r.status !== st || r.entry_count !== cnt))
        begin
            errors++;
            $display("%0t: table row disagrees expected %0d/%0d predicted %0d/%0d",
                     $time, st, cnt, r.status, r.entry_count);
        end
        expected_q.push_back(r);
        if (op == OP_PUSH)
            pushes_sent++;
        else
            pops_sent++;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_mode(logic m);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        mode_mdl = m;
    endtask

    // random phase: mixed pushes and pops, pop-heavy past 50 entries; tied priorities
    task automatic random_phase(int n);
        logic signed [31:0] v;
        logic signed [31:0] p;
        logic op;
        for (int i = 0; i < n; i++)
        begin
            op = ($urandom_range(0, 99) < ((heap_n > 50) ? 70 : 40));
            v = $urandom;
            case ($urandom_range(0, 3))
                0: p = $urandom;
                1: p = $signed($urandom_range(0, 7)) - 4;
                2: p = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
                default: p = $urandom_range(0, 1000);
            endcase
            if ($urandom_range(0, 4) == 0)
                v = $urandom_range(0, 3);
            send_item(op, v, p, 1'b0, STAT_OK, '0);
        end
    endtask

    initial
    begin
        row_t dir[$];
        row_t r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        errors = 0;
        pushes_sent = 0;
        pops_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        hold_rx = 1'b0;
        sending_done = 1'b0;
        rx_gap_max = 3;
        heap_n = 0;
        mode_mdl = 1'b0;
        foreach (heap_mdl[i])
            heap_mdl[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: short pops, extremes, ties, equal pairs among children
        dir.push_back('{OP_POP, 32'sd5, 32'sd5, 1'b1, STAT_SHORT, 7'd0});
        dir.push_back('{OP_PUSH, 32'sh7fffffff, 32'sh7fffffff, 1'b1, STAT_OK, 7'd1});
        dir.push_back('{OP_POP, 32'sd0, 32'sd0, 1'b1, STAT_SHORT, 7'd1});
        dir.push_back('{OP_PUSH, 32'sh80000000, 32'sh80000000, 1'b1, STAT_OK, 7'd2});
        dir.push_back('{OP_PUSH, 32'sd7, 32'sd3, 1'b1, STAT_OK, 7'd3});
        dir.push_back('{OP_PUSH, 32'sd8, 32'sd3, 1'b1, STAT_OK, 7'd4});
        dir.push_back('{OP_PUSH, -32'sd1, 32'sd3, 1'b1, STAT_OK, 7'd5});
        dir.push_back('{OP_POP, 32'sh7fffffff, -32'sd1, 1'b1, STAT_OK, 7'd4});
        dir.push_back('{OP_POP, 32'sd0, 32'sd0, 1'b1, STAT_OK, 7'd3});
        dir.push_back('{OP_POP, 32'sd0, 32'sd0, 1'b1, STAT_OK, 7'd2});
        dir.push_back('{OP_POP, 32'sd0, 32'sd0, 1'b1, STAT_OK, 7'd1});
        // equal pairs: identical children under the root
        dir.push_back('{OP_PUSH, 32'sd9, 32'sd9, 1'b1, STAT_OK, 7'd2});
        dir.push_back('{OP_PUSH, 32'sd9, 32'sd9, 1'b1, STAT_OK, 7'd3});
        dir.push_back('{OP_PUSH, 32'sd9, 32'sd9, 1'b1, STAT_OK, 7'd4});
        dir.push_back('{OP_POP, 32'sd0, 32'sd0, 1'b1, STAT_OK, 7'd3});
        dir.push_back('{OP_POP, 32'sd0, 32'sd0, 1'b1, STAT_OK, 7'd2});
        dir.push_back('{OP_POP, 32'sd0, 32'sd0, 1'b1, STAT_OK, 7'd1});
        foreach (dir[i])
        begin
            r = dir[i];
            send_item(r.op, r.val, r.pri, r.typed, r.status, r.count);
        end
        drain();

        // fill to capacity, then full pushes; receiver held off meanwhile
        write_mode(1'b1);
        fork
            begin
                hold_rx = 1'b1;
                repeat (300) @(posedge clk);
                hold_rx = 1'b0;
            end
        join_none
        while (heap_n < CAP)
            send_item(OP_PUSH, $urandom, $urandom, 1'b0, STAT_OK, '0);
        send_item(OP_PUSH, 32'sh80000000, 32'sh7fffffff, 1'b1, STAT_FULL, 7'd64);
        send_item(OP_PUSH, -32'sd1, 32'sd0, 1'b1, STAT_FULL, 7'd64);
        drain();

        // random phases across both orders
        rx_gap_max = 20;
        random_phase(250);
        drain();
        write_mode(1'b0);
        random_phase(300);
        drain();
        write_mode(1'b1);
        rx_gap_max = 2;
        random_phase(250);
        sending_done = 1'b1;
        drain();

        $display("covered %0d pushes and %0d pops over both priority orders,",
                 pushes_sent, pops_sent);
        $display("including full heap, short pops, ties and %0d checked results",
                 results_seen);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
